// ----- rtl/glyph_slot_mru_cache_defines.svh -----
// Assertion macros for the glyph slot MRU cache checker.
// Depends on nothing; included by the checker file by its bare name.
`ifndef GLYPH_SLOT_MRU_CACHE_DEFINES_SVH
`define GLYPH_SLOT_MRU_CACHE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GSMC_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GSMC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/gsmc_pkg.sv -----
// Shared constants, types and structs for the glyph slot MRU cache.
// Depends on nothing; used by gsmc_match, gsmc_list and glyph_slot_mru_cache.
`default_nettype none

package gsmc_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CODE_W  = 8;
  localparam int SLOT_W  = 3;

  localparam logic [CODE_W-1:0] RESET_CODE = 8'h80;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // Outcome of the lookup: whether the code is present and where.
  typedef struct packed {
    logic hit;
    idx_t pos;
  } lookup_t;

  // Result handed from the list to the output register.
  typedef struct packed {
    slot_t slot;
    logic  hit;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/gsmc_match.sv -----
// Parallel compare of a request code against every entry and a priority pick.
// Depends on gsmc_pkg.
`default_nettype none

module gsmc_match (
  input  wire gsmc_pkg::code_t   req_code,
  input  wire gsmc_pkg::code_t   codes [gsmc_pkg::ENTRIES],
  output gsmc_pkg::lookup_t      lookup
);

  // Scanning from the back lets the frontmost match win.
  always_comb begin
    lookup.hit = 1'b0;
    lookup.pos = gsmc_pkg::IDX_W'(gsmc_pkg::ENTRIES - 1);
    for (int k = gsmc_pkg::ENTRIES - 1; k >= 0; k--) begin
      if (codes[k] == req_code) begin
        lookup.hit = 1'b1;
        lookup.pos = gsmc_pkg::IDX_W'(k);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gsmc_list.sv -----
// Entry list in recency order, with the move-to-front update.
// Depends on gsmc_pkg and gsmc_match.
`default_nettype none

module gsmc_list (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    upd_en,
  input  wire gsmc_pkg::code_t   req_code,
  output gsmc_pkg::result_t      result
);

  gsmc_pkg::code_t   entry_code      [gsmc_pkg::ENTRIES];
  gsmc_pkg::slot_t   entry_slot      [gsmc_pkg::ENTRIES];
  gsmc_pkg::code_t   entry_code_next [gsmc_pkg::ENTRIES];
  gsmc_pkg::slot_t   entry_slot_next [gsmc_pkg::ENTRIES];
  gsmc_pkg::lookup_t lookup;
  gsmc_pkg::slot_t   moved_slot;

  gsmc_match u_match (
    .req_code (req_code),
    .codes    (entry_code),
    .lookup   (lookup)
  );

  // On a miss the lookup already points at the last entry, which keeps its
  // slot and takes the new code; on a hit the code is unchanged anyway.
  assign moved_slot  = entry_slot[lookup.pos];
  assign result.slot = moved_slot;
  assign result.hit  = lookup.hit;

  always_comb begin
    for (int k = 0; k < gsmc_pkg::ENTRIES; k++) begin
      if (k == 0) begin
        entry_code_next[k] = req_code;
        entry_slot_next[k] = moved_slot;
      end else if (gsmc_pkg::IDX_W'(k) <= lookup.pos) begin
        entry_code_next[k] = entry_code[k-1];
        entry_slot_next[k] = entry_slot[k-1];
      end else begin
        entry_code_next[k] = entry_code[k];
        entry_slot_next[k] = entry_slot[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < gsmc_pkg::ENTRIES; k++) begin
        entry_code[k] <= gsmc_pkg::RESET_CODE;
        entry_slot[k] <= gsmc_pkg::SLOT_W'(k);
      end
    end else if (upd_en) begin
      for (int k = 0; k < gsmc_pkg::ENTRIES; k++) begin
        entry_code[k] <= entry_code_next[k];
        entry_slot[k] <= entry_slot_next[k];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/glyph_slot_mru_cache.sv -----
// Glyph slot MRU cache: an input transaction is held in the input register,
// looked up, and its result captured in the result register, from which the
// sink takes it. One request per cycle is sustained while the sink keeps
// m_tready high.
// The entry list, with its combinational lookup and move-to-front update,
// sits between the input and the result register.
// Reset (rst, synchronous, active high) empties both registers and returns
// the list to codes 0x80 with slots 0 to ENTRIES-1 in order.
// Depends on gsmc_pkg, gsmc_list and gsmc_match.
`default_nettype none

module glyph_slot_mru_cache (
  input  wire        clk,
  input  wire        rst,
  // Request channel.
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // [7:0] char_code
  // Result channel.
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata,   // [2:0] slot, [7:3] zero
  output logic [0:0] m_tuser    // [0] was_hit
);

  // Input register: holds one accepted request until it is looked up.
  logic              in_vld;
  gsmc_pkg::code_t   in_code;

  // Result register: holds one finished result until the sink takes it.
  logic              out_vld;
  gsmc_pkg::result_t out_res;

  gsmc_pkg::result_t list_res;
  logic              advance;

  // A request is looked up, and the list updated, in the same cycle in which
  // its result is captured, so the next request always sees the new order.
  assign advance  = in_vld && (!out_vld || m_tready);

  // The input register frees up whenever its occupant advances, so a new
  // transaction can be taken in that cycle even when the register is full.
  assign s_tready = !in_vld || advance;

  gsmc_list u_list (
    .clk      (clk),
    .rst      (rst),
    .upd_en   (advance),
    .req_code (in_code),
    .result   (list_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_code <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= list_res;
    end
  end

  assign m_tvalid   = out_vld;
  assign m_tdata    = {(8 - gsmc_pkg::SLOT_W)'(0), out_res.slot};
  assign m_tuser[0] = out_res.hit;

endmodule

`default_nettype wire

// ----- rtl/gsmc_checker.sv -----
// Port-level checks for the glyph slot MRU cache, and their bind.
// Depends on glyph_slot_mru_cache_defines.svh and glyph_slot_mru_cache.
`default_nettype none
`include "glyph_slot_mru_cache_defines.svh"

module gsmc_checker (
  input wire       clk,
  input wire       rst,
  input wire       s_tvalid,
  input wire       s_tready,
  input wire       m_tvalid,
  input wire       m_tready,
  input wire [7:0] m_tdata,
  input wire [0:0] m_tuser
);

  // A stalled result keeps its contents.
  `GSMC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // The slot is three bits wide; the rest of tdata is padding.
  `GSMC_ASSERT_NOW(a_pad_zero, clk, rst, m_tvalid, m_tdata[7:3] == 5'd0, "tdata padding not zero")

  // With no result pending the block always takes a request.
  `GSMC_ASSERT_NOW(a_ready_empty, clk, rst, !m_tvalid, s_tready, "request refused with output empty")

  // A request taken while the output is empty is offered as a result once it
  // has passed through the input register.
  `GSMC_ASSERT_NEXT(a_latency, clk, rst, s_tvalid && s_tready && !m_tvalid, ##1 m_tvalid, "result missing after request")

endmodule

bind glyph_slot_mru_cache gsmc_checker u_gsmc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- dv/glyph_slot_mru_cache_tb.sv -----
// Self-checking testbench for glyph_slot_mru_cache: streams character codes in and
// checks every slot and hit flag against a behavioural model of the MRU list.
// Depends on gsmc_pkg and the glyph_slot_mru_cache RTL.
`timescale 1ns / 1ps

module glyph_slot_mru_cache_tb;

  localparam int IDLE_PERCENT = 38;
  localparam int CYCLE_LIMIT  = 200000;
  // The result register directly follows the input register, so the
  // SETTLE_CYCLES wait at the end is plenty to catch a stray result.
  localparam int SETTLE_CYCLES = 8;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = '0;   // [7:0] char_code
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;         // [2:0] slot, [7:3] zero
  logic [0:0] m_tuser;         // [0] was_hit

  glyph_slot_mru_cache dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Model of the list, most recently used entry at index 0.
  gsmc_pkg::code_t   mru_code [gsmc_pkg::ENTRIES];
  gsmc_pkg::slot_t   mru_slot [gsmc_pkg::ENTRIES];
  gsmc_pkg::result_t expected_results[$];

  int fail_count = 0;
  int cycle_count = 0;

  // Each side can be told to idle at random; the hold-off request is taken
  // over and counted down by the receiving process itself.
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  int hold_off_request = 0;
  int hold_off_left = 0;

  // Looks up a code, moves the frontmost match (or, on a miss, the last entry
  // with the new code) to the front and returns its slot and the hit flag.
  function automatic gsmc_pkg::result_t promote_code(input gsmc_pkg::code_t code);
    int                pos;
    gsmc_pkg::code_t   moved_code;
    gsmc_pkg::slot_t   moved_slot;
    gsmc_pkg::result_t res;
    pos = gsmc_pkg::ENTRIES;
    for (int k = gsmc_pkg::ENTRIES - 1; k >= 0; k--) begin
      if (mru_code[k] == code) begin
        pos = k;
      end
    end
    res.hit = (pos < gsmc_pkg::ENTRIES);
    if (!res.hit) begin
      pos = gsmc_pkg::ENTRIES - 1;
      mru_code[pos] = code;
    end
    moved_code = mru_code[pos];
    moved_slot = mru_slot[pos];
    for (int k = pos; k > 0; k--) begin
      mru_code[k] = mru_code[k - 1];
      mru_slot[k] = mru_slot[k - 1];
    end
    mru_code[0] = moved_code;
    mru_slot[0] = moved_slot;
    res.slot = moved_slot;
    return res;
  endfunction

  // Offers one code and returns at the edge where the transaction is taken.
  // Random idle cycles go in front of it when the sender is set to idle, and
  // the data bus carries noise while valid is low.
  task automatic send_code(input gsmc_pkg::code_t code);
    while (sender_idles && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    expected_results.push_back(promote_code(code));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Mixes codes already in the list, at any position, with codes drawn from
  // the whole range so that both hits and evictions stay frequent.
  task automatic send_mixed_codes(input int count, input int hit_percent);
    gsmc_pkg::code_t code;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < hit_percent) begin
        code = mru_code[$urandom_range(0, gsmc_pkg::ENTRIES - 1)];
      end else begin
        code = 8'($urandom_range(0, 255));
      end
      send_code(code);
    end
  endtask

  // Right after reset every entry holds 0x80: the front copy must win and the
  // others must stay put. The extremes of the code range then evict from the back.
  task automatic test_reset_contents();
    send_code(8'h80);
    send_code(8'h80);
    send_code(8'h00);
    send_code(8'hFF);
    send_code(8'h80);
    send_code(8'h7F);
  endtask

  // The driver fills the cache with 0xA0 to 0xA7 through ordinary requests;
  // then hits at the front, the back and the middle of the list, and two misses.
  task automatic test_preload_and_hits();
    for (int c = 8'hA0; c <= 8'hA7; c++) begin
      send_code(gsmc_pkg::code_t'(c));
    end
    send_code(8'hA7);
    send_code(8'hA0);
    send_code(8'hA3);
    send_code(8'hA1);
    send_code(8'h55);
    send_code(8'hAA);
  endtask

  task automatic test_random_traffic();
    send_mixed_codes(150, 65);
  endtask

  // Both sides keep their handshake high throughout, so the block has to
  // sustain one transaction per cycle.
  task automatic test_no_idle_stretch();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    send_mixed_codes(90, 60);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // The receiver stops for a long time while requests keep coming, so the
  // block fills up and must hold its input off without losing anything.
  task automatic test_output_hold_off();
    sender_idles = 1'b0;
    hold_off_request = 120;
    send_mixed_codes(40, 50);
    sender_idles = 1'b1;
  endtask

  // The sender waits until every result is back before it carries on.
  task automatic test_drain_pause();
    send_mixed_codes(25, 60);
    drain_results();
    send_mixed_codes(90, 70);
  endtask

  // Drives m_tready and checks each result transaction against the oldest
  // expectation. Values read here are those present at the clock edge.
  always @(posedge clk) begin
    if (hold_off_request != 0) begin
      hold_off_left = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(receiver_idles && $urandom_range(0, 99) < IDLE_PERCENT);
    end

    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no request outstanding: slot %0d, was_hit %0d",
               m_tdata[2:0], m_tuser[0]);
        fail_count++;
      end else begin
        automatic gsmc_pkg::result_t exp_res = expected_results.pop_front();
        if (m_tdata[2:0] !== exp_res.slot) begin
          $error("slot: expected %0d, got %0d", exp_res.slot, m_tdata[2:0]);
          fail_count++;
        end
        if (m_tuser[0] !== exp_res.hit) begin
          $error("was_hit: expected %0d, got %0d", exp_res.hit, m_tuser[0]);
          fail_count++;
        end
        if (m_tdata[7:3] !== 5'd0) begin
          $error("tdata padding: expected 0, got 0x%0h", m_tdata[7:3]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("glyph_slot_mru_cache_tb failed");
    $finish;
  end

  initial begin
    for (int k = 0; k < gsmc_pkg::ENTRIES; k++) begin
      mru_code[k] = gsmc_pkg::RESET_CODE;
      mru_slot[k] = gsmc_pkg::slot_t'(k);
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_contents();
    test_preload_and_hits();
    test_random_traffic();
    test_no_idle_stretch();
    test_output_hold_off();
    test_drain_pause();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("glyph_slot_mru_cache_tb passed");
    end else begin
      $display("glyph_slot_mru_cache_tb failed");
    end
    $finish;
  end

endmodule
